@@ hdl/hsl2rgb_pkg.sv @@
// Shared types and constants for the HSL to RGB pixel converter.
// No dependencies; used by every module under hdl.
package hsl2rgb_pkg;

  localparam int unsigned HueW   = 15;
  localparam int unsigned UnitW  = 9;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned ChromaW = 17;
  localparam int unsigned WeightW = 12;
  localparam int unsigned TermW  = 29;

  localparam logic [HueW-1:0]    HueFull   = 15'd23040;
  localparam logic [HueW-1:0]    HueSector = 15'd3840;
  localparam logic [UnitW-1:0]   Unit      = 9'd256;
  localparam logic [TermW-1:0]   LightGain = 29'd983040;
  localparam logic [TermW-1:0]   HalfSect  = 29'd1920;
  localparam logic [TermW-1:0]   SectGain  = 29'd3840;
  localparam logic [TermW:0]     ScaleD    = 30'd251658240;

  typedef enum logic [2:0] {
    SEC_CX0 = 3'd0,
    SEC_XC0 = 3'd1,
    SEC_0CX = 3'd2,
    SEC_0XC = 3'd3,
    SEC_X0C = 3'd4,
    SEC_C0X = 3'd5
  } sector_e;

  typedef struct packed {
    logic [ChromaW-1:0] chroma;
    logic [UnitW-1:0]   light;
    logic [WeightW-1:0] weight;
    sector_e            sector;
  } prep_t;

  typedef struct packed {
    logic [TermW-1:0] cd;
    logic [TermW-1:0] xd;
    logic [TermW-1:0] md;
    sector_e          sector;
  } terms_t;

endpackage

@@ hdl/hsl2rgb_prep.sv @@
// Stages one and two: input limiting, hue sector and weight, chroma product.
// Depends on hsl2rgb_pkg.
module hsl2rgb_prep (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [hsl2rgb_pkg::HueW-1:0]    hue_i,
  input  logic [hsl2rgb_pkg::UnitW-1:0]   sat_i,
  input  logic [hsl2rgb_pkg::UnitW-1:0]   light_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output hsl2rgb_pkg::prep_t              out_o
);

  logic                             v1_q, v2_q, adv1, adv2;
  logic [hsl2rgb_pkg::HueW-1:0]     h_w;
  logic [12:0]                      h_m;
  logic [11:0]                      tri_w;
  logic [hsl2rgb_pkg::UnitW-1:0]    s_c, l_c, cf;
  logic [hsl2rgb_pkg::UnitW:0]      l2, spread;
  hsl2rgb_pkg::sector_e             sec;
  logic [hsl2rgb_pkg::UnitW-1:0]    cf_q, s_q, l1_q;
  logic [hsl2rgb_pkg::WeightW-1:0]  wt_d, wt1_q;
  hsl2rgb_pkg::sector_e             sec1_q;
  hsl2rgb_pkg::prep_t               p2_d, p2_q;
  logic [17:0]                      prod;

  assign adv2       = !v2_q || out_ready_i;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  always_comb begin
    h_w = (hue_i >= hsl2rgb_pkg::HueFull) ? hue_i - hsl2rgb_pkg::HueFull : hue_i;
    s_c = (sat_i > hsl2rgb_pkg::Unit) ? hsl2rgb_pkg::Unit : sat_i;
    l_c = (light_i > hsl2rgb_pkg::Unit) ? hsl2rgb_pkg::Unit : light_i;
    l2  = {l_c, 1'b0};
    spread = (l2 >= 10'(hsl2rgb_pkg::Unit)) ? l2 - 10'(hsl2rgb_pkg::Unit)
                                           : 10'(hsl2rgb_pkg::Unit) - l2;
    cf  = hsl2rgb_pkg::Unit - spread[8:0];
    if (h_w >= 15'd15360) begin
      h_m = 13'(h_w - 15'd15360);
    end else if (h_w >= 15'd7680) begin
      h_m = 13'(h_w - 15'd7680);
    end else begin
      h_m = h_w[12:0];
    end
    tri_w = (h_m >= 13'(hsl2rgb_pkg::HueSector)) ? 12'(h_m - 13'(hsl2rgb_pkg::HueSector))
                                                 : 12'(13'(hsl2rgb_pkg::HueSector) - h_m);
    wt_d = 12'(hsl2rgb_pkg::HueSector) - tri_w;
    if (h_w >= 15'd19200) begin
      sec = hsl2rgb_pkg::SEC_C0X;
    end else if (h_w >= 15'd15360) begin
      sec = hsl2rgb_pkg::SEC_X0C;
    end else if (h_w >= 15'd11520) begin
      sec = hsl2rgb_pkg::SEC_0XC;
    end else if (h_w >= 15'd7680) begin
      sec = hsl2rgb_pkg::SEC_0CX;
    end else if (h_w >= hsl2rgb_pkg::HueSector) begin
      sec = hsl2rgb_pkg::SEC_XC0;
    end else begin
      sec = hsl2rgb_pkg::SEC_CX0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      cf_q   <= cf;
      s_q    <= s_c;
      l1_q   <= l_c;
      wt1_q  <= wt_d;
      sec1_q <= sec;
    end
  end

  assign prod = 18'(cf_q) * 18'(s_q);

  always_comb begin
    p2_d.chroma = prod[hsl2rgb_pkg::ChromaW-1:0];
    p2_d.light  = l1_q;
    p2_d.weight = wt1_q;
    p2_d.sector = sec1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      p2_q <= p2_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign out_o       = p2_q;

  a_chroma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> p2_q.chroma <= 17'd65536)
    else $error("chroma above full scale");

endmodule

@@ hdl/hsl2rgb_terms.sv @@
// Stage three: chroma, secondary and offset terms on the common scale.
// Depends on hsl2rgb_pkg.
module hsl2rgb_terms (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hsl2rgb_pkg::prep_t   in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hsl2rgb_pkg::terms_t  out_o
);

  logic                 v_q, adv;
  hsl2rgb_pkg::terms_t  t_d, t_q;
  logic [hsl2rgb_pkg::TermW-1:0] chroma_w;

  assign adv        = !v_q || out_ready_i;
  assign in_ready_o = adv;
  assign chroma_w   = hsl2rgb_pkg::TermW'(in_i.chroma);

  always_comb begin
    t_d.cd     = chroma_w * hsl2rgb_pkg::SectGain;
    t_d.xd     = chroma_w * hsl2rgb_pkg::TermW'(in_i.weight);
    t_d.md     = hsl2rgb_pkg::TermW'(in_i.light) * hsl2rgb_pkg::LightGain
               - chroma_w * hsl2rgb_pkg::HalfSect;
    t_d.sector = in_i.sector;
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      t_q <= t_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= in_valid_i;
    end
  end

  assign out_valid_o = v_q;
  assign out_o       = t_q;

  a_peak_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> ({1'b0, t_q.cd} + {1'b0, t_q.md}) <= hsl2rgb_pkg::ScaleD)
    else $error("chroma plus offset above full scale");

  a_x_below_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> t_q.xd <= t_q.cd)
    else $error("secondary term above chroma");

endmodule

@@ hdl/hsl2rgb_mix.sv @@
// Stages four and five: sector routing, offset add, scale to 8 bits, output register.
// Depends on hsl2rgb_pkg.
module hsl2rgb_mix (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  hsl2rgb_pkg::terms_t                in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [hsl2rgb_pkg::ChanW-1:0]      red_o,
  output logic [hsl2rgb_pkg::ChanW-1:0]      green_o,
  output logic [hsl2rgb_pkg::ChanW-1:0]      blue_o
);

  localparam int unsigned W = hsl2rgb_pkg::TermW;

  logic           v4_q, v5_q, adv4, adv5;
  logic [W-1:0]   vr, vg, vb;
  logic [W-1:0]   r_q, g_q, b_q;
  logic [hsl2rgb_pkg::ChanW-1:0] r_d, g_d, b_d;
  logic [hsl2rgb_pkg::ChanW-1:0] r5_q, g5_q, b5_q;

  function automatic logic [hsl2rgb_pkg::ChanW-1:0] scale8(input logic [W-1:0] sum);
    logic [W+3:0] p;
    logic [W+3-24:0] q;
    p = {sum, 4'b0} + (W+4)'(sum);
    q = p[W+3:24];
    return (q > (W+4-24)'(255)) ? 8'd255 : q[7:0];
  endfunction

  assign adv5       = !v5_q || out_ready_i;
  assign adv4       = !v4_q || adv5;
  assign in_ready_o = adv4;

  always_comb begin
    unique case (in_i.sector)
      hsl2rgb_pkg::SEC_CX0: begin vr = in_i.cd; vg = in_i.xd; vb = '0;      end
      hsl2rgb_pkg::SEC_XC0: begin vr = in_i.xd; vg = in_i.cd; vb = '0;      end
      hsl2rgb_pkg::SEC_0CX: begin vr = '0;      vg = in_i.cd; vb = in_i.xd; end
      hsl2rgb_pkg::SEC_0XC: begin vr = '0;      vg = in_i.xd; vb = in_i.cd; end
      hsl2rgb_pkg::SEC_X0C: begin vr = in_i.xd; vg = '0;      vb = in_i.cd; end
      default:              begin vr = in_i.cd; vg = '0;      vb = in_i.xd; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv4 && in_valid_i) begin
      r_q <= vr + in_i.md;
      g_q <= vg + in_i.md;
      b_q <= vb + in_i.md;
    end
  end

  always_comb begin
    r_d = scale8(r_q);
    g_d = scale8(g_q);
    b_d = scale8(b_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv5 && v4_q) begin
      r5_q <= r_d;
      g5_q <= g_d;
      b5_q <= b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (adv4) v4_q <= in_valid_i;
      if (adv5) v5_q <= v4_q;
    end
  end

  assign out_valid_o = v5_q;
  assign red_o       = r5_q;
  assign green_o     = g5_q;
  assign blue_o      = b5_q;

  a_sum_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> ({1'b0, r_q} <= hsl2rgb_pkg::ScaleD) && ({1'b0, g_q} <= hsl2rgb_pkg::ScaleD)
          && ({1'b0, b_q} <= hsl2rgb_pkg::ScaleD))
    else $error("channel sum above full scale");

endmodule

@@ hdl/hsl_to_rgb_converter_top.sv @@
// Top level of the HSL to RGB pixel converter: five-stage pipeline.
// Depends on hsl2rgb_pkg, hsl2rgb_prep, hsl2rgb_terms, hsl2rgb_mix.
//
//   channel   direction  handshake                    tdata (low bit up)
//   s_axis    in         s_axis_tvalid/s_axis_tready  hue[14:0] sat[23:15] light[32:24]
//   m_axis    out        m_axis_tvalid/m_axis_tready  red[7:0] green[15:8] blue[23:16]
//
// One beat per cycle sustained while m_axis_tready is high.
// Stages: limit and sector, 9x9 chroma multiply, 17x12 secondary multiply,
// offset add, scale by 17/2^24 into the output register.
// Reset clears the stage valid bits only. A stall on m_axis holds the full stages at the
// output end; an empty stage still fills, so s_axis stays ready until all five stages hold beats.
module hsl_to_rgb_converter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // hue[14:0], saturation[23:15], lightness[32:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

  logic                p_valid, p_ready, t_valid, t_ready;
  hsl2rgb_pkg::prep_t  p_data;
  hsl2rgb_pkg::terms_t t_data;
  logic [7:0]          red, green, blue;

  hsl2rgb_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .hue_i       (s_axis_tdata[14:0]),
    .sat_i       (s_axis_tdata[23:15]),
    .light_i     (s_axis_tdata[32:24]),
    .out_valid_o (p_valid),
    .out_ready_i (p_ready),
    .out_o       (p_data)
  );

  hsl2rgb_terms u_terms (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p_valid),
    .in_ready_o  (p_ready),
    .in_i        (p_data),
    .out_valid_o (t_valid),
    .out_ready_i (t_ready),
    .out_o       (t_data)
  );

  hsl2rgb_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (t_valid),
    .in_ready_o  (t_ready),
    .in_i        (t_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue)
  );

  assign m_axis_tdata = {blue, green, red};

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && t_valid && p_valid)
    else $error("input stalled with room in the pipeline");

endmodule

@@ tb/tb_hsl_to_rgb_converter_top.sv @@
// Self-checking bench for hsl_to_rgb_converter_top: directed pixel table, then random pixels.
// Each output beat is checked against the known table RGB or an in-bench integer predictor.
// Depends on hsl2rgb_pkg and hdl/hsl_to_rgb_converter_top.sv.
module tb_hsl_to_rgb_converter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandPixels = 850;
  localparam int unsigned DrainCycles = 12;
  localparam logic [63:0] HueSpan = 64'd23040;
  localparam logic [63:0] SectorSpan = 64'd3840;
  localparam logic [63:0] FullUnit = 64'd256;
  localparam logic [63:0] ChanScale = 64'd65536 * 64'd3840;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [8:0]  sat;
    logic [8:0]  light;
    logic        known;
    pixel_t      rgb;
  } pixel_row_t;

  localparam int NumRows = 23;
  localparam pixel_row_t PixelRows [NumRows] = '{
    '{15'd0,     9'd0,   9'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{15'd0,     9'd0,   9'd256, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{15'd0,     9'd256, 9'd128, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{15'd7680,  9'd256, 9'd128, 1'b1, '{8'd0,   8'd255, 8'd0}},
    '{15'd15360, 9'd256, 9'd128, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{15'd0,     9'd0,   9'd128, 1'b1, '{8'd127, 8'd127, 8'd127}},
    '{15'd23040, 9'd256, 9'd128, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{15'd32767, 9'd511, 9'd511, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{15'd0,     9'd511, 9'd128, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{15'd16384, 9'd511, 9'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{15'd23041, 9'd256, 9'd511, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{15'd1920,  9'd256, 9'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd5760,  9'd256, 9'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd9600,  9'd256, 9'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd13440, 9'd256, 9'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd17280, 9'd256, 9'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd21120, 9'd256, 9'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd3839,  9'd200, 9'd100, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd3840,  9'd200, 9'd100, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd11520, 9'd256, 9'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd23039, 9'd256, 9'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd32767, 9'd256, 9'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{15'd12345, 9'd1,   9'd1,   1'b0, '{8'd0,   8'd0,   8'd0}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  pixel_t      rgb_q[$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;

  hsl_to_rgb_converter_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [7:0] to_chan(logic [63:0] level);
    logic [63:0] q;
    q = (level * 64'd255) / ChanScale;
    return (q > 64'd255) ? 8'd255 : q[7:0];
  endfunction

  function automatic pixel_t hsl_to_pixel(logic [14:0] hue, logic [8:0] sat,
                                          logic [8:0] light);
    logic [63:0] h, s, l, spread, chroma, phase, ramp, c_term, x_term, m_term;
    logic [63:0] r, g, b;
    hsl2rgb_pkg::sector_e sec;
    pixel_t      px;
    h = 64'(hue);
    s = 64'(sat);
    l = 64'(light);
    if (h >= HueSpan) h = h - HueSpan;
    if (s > FullUnit) s = FullUnit;
    if (l > FullUnit) l = FullUnit;
    spread = (2 * l >= FullUnit) ? (2 * l - FullUnit) : (FullUnit - 2 * l);
    chroma = (FullUnit - spread) * s;
    phase = h % (2 * SectorSpan);
    ramp = (phase >= SectorSpan) ? (phase - SectorSpan) : (SectorSpan - phase);
    c_term = chroma * SectorSpan;
    x_term = chroma * (SectorSpan - ramp);
    m_term = l * FullUnit * SectorSpan - chroma * (SectorSpan / 2);
    sec = hsl2rgb_pkg::sector_e'(3'(h / SectorSpan));
    case (sec)
      hsl2rgb_pkg::SEC_CX0: begin r = c_term; g = x_term; b = 0;      end
      hsl2rgb_pkg::SEC_XC0: begin r = x_term; g = c_term; b = 0;      end
      hsl2rgb_pkg::SEC_0CX: begin r = 0;      g = c_term; b = x_term; end
      hsl2rgb_pkg::SEC_0XC: begin r = 0;      g = x_term; b = c_term; end
      hsl2rgb_pkg::SEC_X0C: begin r = x_term; g = 0;      b = c_term; end
      default:              begin r = c_term; g = 0;      b = x_term; end
    endcase
    px.red = to_chan(r + m_term);
    px.green = to_chan(g + m_term);
    px.blue = to_chan(b + m_term);
    return px;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [8:0] pick_unit();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 9'($urandom_range(257, 511));
    if (roll < 14) return (roll < 11) ? 9'd0 : 9'd256;
    return 9'($urandom_range(0, 256));
  endfunction

  task automatic send_pixel(logic [14:0] hue, logic [8:0] sat, logic [8:0] light,
                            logic known, pixel_t rgb);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, light, sat, hue};
    do @(posedge clk_i); while (!s_axis_tready);
    rgb_q.push_back(known ? rgb : hsl_to_pixel(hue, sat, light));
  endtask

  // sink side: random stalls, no new ones while quiet
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 25) stall_left <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.red = m_axis_tdata[7:0];
      got.green = m_axis_tdata[15:8];
      got.blue = m_axis_tdata[23:16];
      if (rgb_q.size() == 0) begin
        $error("unexpected output beat: tdata %06h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = rgb_q.pop_front();
        if (got.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, got.red);
          err_cnt++;
        end
        if (got.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, got.green);
          err_cnt++;
        end
        if (got.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, got.blue);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [14:0] hue;
    logic [8:0]  sat, light;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (PixelRows[i]) begin
      send_pixel(PixelRows[i].hue, PixelRows[i].sat, PixelRows[i].light,
                 PixelRows[i].known, PixelRows[i].rgb);
    end
    for (int unsigned i = 0; i < RandPixels; i++) begin
      if (i % 100 == 0) quiet = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 99) < 85) hue = 15'($urandom_range(0, 23039));
      else hue = 15'($urandom_range(23040, 32767));
      sat = pick_unit();
      light = pick_unit();
      send_pixel(hue, sat, light, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b1;
    while (rgb_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
